FILE: sv/tcmq_pkg.sv
// Shared types and constants of the two-class multi-queue block.
package tcmq_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned STATUS_W = 2;

  // Queue limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  // Operation carried by a request.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // Outcome reported with every result.
  typedef enum logic [STATUS_W-1:0] {
    STAT_PUSHED   = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_POPPED   = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_META,
    FSM_ENTRY
  } fsm_e;

endpackage

FILE: sv/two_class_multi_queue_core.sv
// A push or a pop of an empty queue has its result loaded into the output register from
// the META state, a pop that returns an entry from the ENTRY state after the entry read.
// A new request is taken only in the idle state, once the previous one is through, a pace
// set by the head/fill memory read-modify-write and the entry memory read.
// A result waiting in the output register holds the next request in the sequencer.
// Reset clears the sequencer and the per-queue valid bits (all queues empty), limit 5.
module two_class_multi_queue_core
  import tcmq_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_WIDTH   = 16,
  localparam int unsigned IN_BITS    = IDX_W + 1 + TAG_WIDTH,
  localparam int unsigned IN_TW      = 8 * ((IN_BITS + 7) / 8),
  localparam int unsigned OUT_BITS   = TAG_WIDTH + 1,
  localparam int unsigned OUT_TW     = 8 * ((OUT_BITS + 7) / 8)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel: queue limit.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LIMIT_W-1:0]  cfg_data_i,
  // Request stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_TW-1:0]    s_axis_tdata,   // queue_index, urgent, item_tag, zero pad
  input  logic                s_axis_tuser,   // command
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_TW-1:0]   m_axis_tdata,   // popped_tag, popped_urgent, zero pad
  output logic [STATUS_W-1:0] m_axis_tuser    // status
);

  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW  = PW + CW;
  localparam int unsigned NE  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned EAW = (NE > 1) ? $clog2(NE) : 1;
  localparam int unsigned EW  = TAG_WIDTH + 1;

  // Request fields.
  logic [IDX_W-1:0]     in_index;
  logic                 in_urgent;
  logic [TAG_WIDTH-1:0] in_tag;
  logic [QW+IDX_W-1:0]  in_index_wide;
  logic [QW-1:0]        in_qidx;
  logic                 in_range;
  logic                 req_acc;

  assign in_index      = s_axis_tdata[IDX_W-1:0];
  assign in_urgent     = s_axis_tdata[IDX_W];
  assign in_tag        = s_axis_tdata[IDX_W+1 +: TAG_WIDTH];
  assign in_index_wide = {{QW{1'b0}}, in_index};
  assign in_qidx       = in_index_wide[QW-1:0];
  assign in_range      = 32'(in_index) < 32'(NUM_QUEUES);

  // Configuration register.
  logic [LIMIT_W-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Sequencer and captured request.
  fsm_e                 state_q, state_d;
  cmd_e                 cmd_q;
  logic [QW-1:0]        qidx_q;
  logic                 range_q;
  logic                 urg_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [NUM_QUEUES-1:0] meta_vld_q, meta_vld_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [TAG_WIDTH-1:0] out_tag_q, out_tag_d;
  logic                 out_urg_q, out_urg_d;
  logic                 out_free;
  logic                 out_load;

  // Memory ports.
  logic           meta_we, meta_re;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic           ent_we, ent_re;
  logic [EAW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0]  ent_wdata, ent_rdata;

  tcmq_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_QUEUES)
  ) u_meta_ram (
    .clk_i     (clk_i),
    .wr_en_i   (meta_we),
    .wr_addr_i (qidx_q),
    .wr_data_i (meta_wdata),
    .rd_en_i   (meta_re),
    .rd_addr_i (in_qidx),
    .rd_data_o (meta_rdata)
  );

  tcmq_ram #(
    .WIDTH (EW),
    .DEPTH (NE)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ent_we),
    .wr_addr_i (ent_waddr),
    .wr_data_i (ent_wdata),
    .rd_en_i   (ent_re),
    .rd_addr_i (ent_raddr),
    .rd_data_o (ent_rdata)
  );

  // Head and fill of the addressed queue; a never-written queue is empty.
  logic          cur_vld;
  logic [PW-1:0] head;
  logic [CW-1:0] fill;

  assign cur_vld = range_q && meta_vld_q[qidx_q];
  assign head    = cur_vld ? meta_rdata[MW-1:CW] : '0;
  assign fill    = cur_vld ? meta_rdata[CW-1:0] : '0;

  // Pointer arithmetic with wrap at the queue depth.
  logic [7:0]    limit_ext, eff_limit;
  logic          full, empty;
  logic [PW-1:0] head_m1, head_p1, back_pos, push_pos;
  logic [CW:0]   back_sum;
  logic [EAW-1:0] base_addr;

  assign limit_ext = 8'(limit_q);
  assign eff_limit = (limit_ext > 8'(QUEUE_DEPTH)) ? 8'(QUEUE_DEPTH) : limit_ext;
  assign full      = !range_q || (8'(fill) >= eff_limit);
  assign empty     = !range_q || (fill == '0);
  assign head_m1   = (head == '0) ? PW'(QUEUE_DEPTH - 1) : head - PW'(1);
  assign head_p1   = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
  assign back_sum  = (CW+1)'(head) + (CW+1)'(fill);
  assign back_pos  = (back_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     PW'(back_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(back_sum);
  assign push_pos  = urg_q ? head_m1 : back_pos;
  assign base_addr = EAW'(qidx_q) * EAW'(QUEUE_DEPTH);

  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE);
  assign req_acc   = s_axis_tvalid && s_axis_tready;

  // Next state, memory accesses and result loading.
  always_comb begin
    state_d      = state_q;
    meta_re      = 1'b0;
    meta_we      = 1'b0;
    meta_wdata   = {head, fill};
    meta_vld_d   = meta_vld_q;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_waddr    = base_addr + EAW'(push_pos);
    ent_raddr    = base_addr + EAW'(head);
    ent_wdata    = {urg_q, tag_q};
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_urg_d    = out_urg_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (req_acc) begin
          meta_re = 1'b1;
          state_d = FSM_META;
        end
      end
      FSM_META: begin
        if (cmd_q == CMD_POP) begin
          if (!empty) begin
            // Remove the front entry and fetch it.
            meta_we    = 1'b1;
            meta_wdata = {head_p1, fill - CW'(1)};
            ent_re     = 1'b1;
            state_d    = FSM_ENTRY;
          end else if (out_free) begin
            out_load     = 1'b1;
            out_status_d = STAT_EMPTY;
            out_tag_d    = '0;
            out_urg_d    = 1'b0;
            state_d      = FSM_IDLE;
          end
        end else if (out_free) begin
          out_load  = 1'b1;
          out_tag_d = '0;
          out_urg_d = 1'b0;
          state_d   = FSM_IDLE;
          if (full) begin
            out_status_d = STAT_FULL;
          end else begin
            // Urgent items go in front of the head, regular ones behind the tail.
            out_status_d       = STAT_PUSHED;
            ent_we             = 1'b1;
            meta_we            = 1'b1;
            meta_wdata         = {urg_q ? head_m1 : head, fill + CW'(1)};
            meta_vld_d[qidx_q] = 1'b1;
          end
        end
      end
      FSM_ENTRY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = STAT_POPPED;
          out_tag_d    = ent_rdata[TAG_WIDTH-1:0];
          out_urg_d    = ent_rdata[EW-1];
          state_d      = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      meta_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      meta_vld_q  <= meta_vld_d;
    end
  end

  // Captured request and result payload.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      qidx_q  <= in_qidx;
      range_q <= in_range;
      urg_q   <= in_urgent;
      tag_q   <= in_tag;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_tag_q    <= out_tag_d;
      out_urg_q    <= out_urg_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_TW'({out_urg_q, out_tag_q});

endmodule

FILE: sv/tcmq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Storage array and read register; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: tb/sv/tb_two_class_multi_queue_core.sv
// Self-checking testbench for the two-class multi-queue core.
`timescale 1ns / 100ps

module tb_two_class_multi_queue_core
  import tcmq_pkg::*;
();

  localparam int unsigned NUM_QUEUES  = 32;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned IN_TW       = 24;
  localparam int unsigned OUT_TW      = 24;

  localparam int unsigned DIRECTED_ROWS  = 20;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_REQUESTS = 100;
  localparam int unsigned BURST_LEN      = 24;
  localparam int unsigned IDLE_PCT       = 53;
  localparam int unsigned BOTH_IDLE_PCT  = 9;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned PRESSURE_HOLD  = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned EXP_DEPTH      = 16;

  // One queue operation as offered on the request stream.
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] qidx;
    logic             urgent;
    logic [TAG_W-1:0] tag;
  } queue_req_t;

  // One result as returned on the result stream.
  typedef struct packed {
    status_e          status;
    logic [TAG_W-1:0] tag;
    logic             urgent;
  } queue_res_t;

  // Directed row: a request plus an optional hand-written result.
  typedef struct packed {
    queue_req_t req;
    logic       fixed;
    queue_res_t res;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LIMIT_W-1:0]  cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_TW-1:0]    s_axis_tdata = '0;   // queue_index, urgent, item_tag, zero pad
  logic                s_axis_tuser = 1'b0; // command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]   m_axis_tdata;        // popped_tag, popped_urgent, zero pad
  logic [STATUS_W-1:0] m_axis_tuser;        // status

  two_class_multi_queue_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Mirror of the block state: entries, head pointers, fill counts, limit.
  logic [TAG_W:0]         entry_mem [NUM_QUEUES][QUEUE_DEPTH];
  logic [2:0]             head_ptr [NUM_QUEUES];
  logic [3:0]             fill_cnt [NUM_QUEUES];
  logic [LIMIT_W-1:0]     queue_limit = LIMIT_RESET;

  // Expected results in request order, kept in a small ring.
  queue_res_t             exp_fifo [EXP_DEPTH];
  int unsigned            exp_wr_cnt = 0;
  int unsigned            exp_rd_cnt = 0;

  int unsigned            fail_count = 0;
  int unsigned            tx_idle_pct = 0;
  int unsigned            rx_stall_pct = 0;
  int unsigned            rx_hold_cycles = 0;
  int unsigned            requests_sent = 0;
  int unsigned            limit_writes = 0;
  int unsigned            status_seen [4] = '{0, 0, 0, 0};
  logic [IDX_W-1:0]       hot_base = '0;

  // Directed rows at the reset limit of five: empty pops, fill to the limit,
  // a rejected push, urgent items popping last-in first-out ahead of regular
  // ones, head pointer wrap and the highest queue index.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{CMD_POP,  5'd0,  1'b0, 16'h0000}, 1'b1, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd31, 1'b1, 16'hFFFF}, 1'b1, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b0, 16'h0000}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b1, 16'hFFFF}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b0, 16'h1234}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b1, 16'hA5A5}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b0, 16'hFFFF}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd0,  1'b1, 16'h5A5A}, 1'b1, '{STAT_FULL,   16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b0, 16'h0000}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b1, 16'h0000}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b0, 16'hFFFF}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b0, 16'h0000}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b0, 16'h0000}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd0,  1'b0, 16'h0000}, 1'b1, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd31, 1'b1, 16'h8001}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd31, 1'b0, 16'h7FFE}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_POP,  5'd31, 1'b1, 16'hFFFF}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_POP,  5'd31, 1'b0, 16'h0000}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}},
    '{'{CMD_PUSH, 5'd17, 1'b0, 16'hAAAA}, 1'b1, '{STAT_PUSHED, 16'h0, 1'b0}},
    '{'{CMD_POP,  5'd17, 1'b0, 16'h5555}, 1'b0, '{STAT_EMPTY,  16'h0, 1'b0}}
  };

  // Limits used by the random phases, the extremes and out-of-range values included.
  logic [LIMIT_W-1:0] phase_limits [RANDOM_PHASES] = '{
    4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5, 4'd2
  };

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $error("Timeout: the run did not finish in time.");
    $display("TEST FAILED");
    $finish;
  end

  // Deque update for one operation; returns the result the block must report.
  function automatic queue_res_t apply_queue_op(queue_req_t req);
    queue_res_t       res;
    logic [3:0]       eff_limit;
    logic [2:0]       slot;
    res = '{STAT_EMPTY, '0, 1'b0};
    eff_limit = (queue_limit > QUEUE_DEPTH) ? 4'(QUEUE_DEPTH) : queue_limit;
    if (req.cmd == CMD_PUSH) begin
      if (fill_cnt[req.qidx] >= eff_limit) begin
        res.status = STAT_FULL;
      end else begin
        // Urgent items enter in front of the head, regular ones behind the tail.
        if (req.urgent) begin
          head_ptr[req.qidx] = head_ptr[req.qidx] - 3'd1;
          slot = head_ptr[req.qidx];
        end else begin
          slot = head_ptr[req.qidx] + fill_cnt[req.qidx][2:0];
        end
        entry_mem[req.qidx][slot] = {req.urgent, req.tag};
        fill_cnt[req.qidx] = fill_cnt[req.qidx] + 4'd1;
        res.status = STAT_PUSHED;
      end
    end else if (fill_cnt[req.qidx] != 4'd0) begin
      slot = head_ptr[req.qidx];
      res.status = STAT_POPPED;
      res.tag = entry_mem[req.qidx][slot][TAG_W-1:0];
      res.urgent = entry_mem[req.qidx][slot][TAG_W];
      head_ptr[req.qidx] = slot + 3'd1;
      fill_cnt[req.qidx] = fill_cnt[req.qidx] - 4'd1;
    end
    return res;
  endfunction

  // Random operation, mostly aimed at two hot queues, alternating push-heavy
  // and pop-heavy bursts so queues fill to their limit and drain again.
  function automatic queue_req_t random_request(int unsigned n);
    queue_req_t  req;
    int unsigned push_pct;
    push_pct = ((n / BURST_LEN) % 2 == 0) ? 80 : 25;
    req.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
    if ($urandom_range(99) < 85) begin
      req.qidx = hot_base + IDX_W'($urandom_range(1));
    end else begin
      req.qidx = IDX_W'($urandom_range(NUM_QUEUES - 1));
    end
    req.urgent = 1'($urandom_range(1));
    req.tag = TAG_W'($urandom);
    return req;
  endfunction

  // Offer one request, wait for its handshake and record the expected result.
  task automatic send_request(queue_req_t req, logic fixed, queue_res_t fixed_res);
    queue_res_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.cmd;
    s_axis_tdata  <= {2'b00, req.tag, req.urgent, req.qidx};
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_queue_op(req);
    if (exp_wr_cnt - exp_rd_cnt >= EXP_DEPTH) begin
      $error("Too many results outstanding: %0d", exp_wr_cnt - exp_rd_cnt);
      fail_count++;
    end
    exp_fifo[exp_wr_cnt % EXP_DEPTH] = fixed ? fixed_res : res;
    exp_wr_cnt++;
    requests_sent++;
  endtask

  // Wait until every result has come back, plus the pipeline latency.
  task automatic wait_drained();
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the queue limit while the block is idle.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    queue_limit = value;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result receiver: random stalls, plus a counted hold-off on request.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    queue_res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_seen[m_axis_tuser]++;
      if (exp_wr_cnt == exp_rd_cnt) begin
        $error("Result with no request outstanding: status %0d", m_axis_tuser);
        fail_count++;
      end else begin
        exp_res = exp_fifo[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[TAG_W-1:0] !== exp_res.tag) begin
          $error("popped_tag: expected %h, actual %h", exp_res.tag,
                 m_axis_tdata[TAG_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[TAG_W] !== exp_res.urgent) begin
          $error("popped_urgent: expected %0d, actual %0d", exp_res.urgent,
                 m_axis_tdata[TAG_W]);
          fail_count++;
        end
        if (m_axis_tdata[OUT_TW-1:TAG_W+1] !== '0) begin
          $error("pad: expected 0, actual %h", m_axis_tdata[OUT_TW-1:TAG_W+1]);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases.
  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_ptr[q] = '0;
      fill_cnt[q] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset limit, no idling.
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_request(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].res);
    end

    // Random phases, each with its own limit and idling pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_limit(phase_limits[phase]);
      hot_base = IDX_W'($urandom_range(NUM_QUEUES - 1));
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = IDLE_PCT;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = IDLE_PCT;
        end
        default: begin
          tx_idle_pct = BOTH_IDLE_PCT;
          rx_stall_pct = BOTH_IDLE_PCT;
        end
      endcase
      // Hold the receiver off so the block backs up and stalls its input.
      if (phase == PRESSURE_PHASE) begin
        @(posedge clk_i);
        rx_hold_cycles = PRESSURE_HOLD;
      end
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(random_request(n), 1'b0, '{STAT_EMPTY, '0, 1'b0});
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drained();

    if (exp_wr_cnt != exp_rd_cnt) begin
      $error("%0d results never arrived", exp_wr_cnt - exp_rd_cnt);
      fail_count++;
    end
    $display("Sent %0d requests under %0d limit writes, with idle, stall and backpressure.",
             requests_sent, limit_writes);
    $display("Results: %0d pushed, %0d rejected full, %0d popped, %0d found empty.",
             status_seen[STAT_PUSHED], status_seen[STAT_FULL],
             status_seen[STAT_POPPED], status_seen[STAT_EMPTY]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
